// ===== src/ndvi_point_classifier_macros.svh =====
// Assertion macros for the NDVI point classifier.
// Used by the RTL files in this folder; needs clk and rst_n in scope.
`ifndef NDVI_POINT_CLASSIFIER_MACROS_SVH
`define NDVI_POINT_CLASSIFIER_MACROS_SVH

// same-cycle implication
`define NPC_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("npc assertion failed");

// next-cycle implication
`define NPC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("npc assertion failed");

`endif

// ===== src/npc_pkg.sv =====
// Package for the NDVI point classifier: fixed-point format, register
// indexes, sequencer states and divider status. No dependencies.
`default_nettype none

package npc_pkg;

  localparam int NDVI_FRAC_BITS = 14;
  localparam int QW             = NDVI_FRAC_BITS + 1;
  localparam int CNT_W          = $clog2(QW);

  localparam logic signed [15:0] NDVI_ONE =
    (NDVI_FRAC_BITS >= 15) ? 16'sh7FFF : 16'(32'sd1 <<< NDVI_FRAC_BITS);
  localparam logic signed [15:0] NDVI_NEG_ONE = 16'(-(32'sd1 <<< NDVI_FRAC_BITS));
  localparam logic signed [16:0] NDVI_SAT_MAX = 17'sd32767;

  localparam logic [15:0] MIN_DEPTH_RESET = 16'd10;

  typedef enum logic [2:0] {
    CFG_NDVI_THRESHOLD     = 3'd0,
    CFG_IR_THRESHOLD       = 3'd1,
    CFG_GROUND_MODE        = 3'd2,
    CFG_PLANT_MODE         = 3'd3,
    CFG_TINT_LOW_NDVI      = 3'd4,
    CFG_TINT_DARK_IR       = 3'd5,
    CFG_SHOW_OUTSIDE_COLOR = 3'd6,
    CFG_MIN_DEPTH_MM       = 3'd7
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_DONE
  } npc_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

`default_nettype wire

// ===== src/npc_divider.sv =====
// Bit-serial restoring divider: dividend << NDVI_FRAC_BITS over a 9-bit
// divisor, for dividend <= divisor. Depends on npc_pkg.
`default_nettype none

module npc_divider (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   start,
  input  wire logic [7:0]             dividend,
  input  wire logic [8:0]             divisor,
  output npc_pkg::div_status_t        status,
  output logic [npc_pkg::QW-1:0]      quotient
);
  import npc_pkg::*;

  logic [8:0]       rem_r, rem_nxt;
  logic [8:0]       dsr_r, dsr_nxt;
  logic [QW-1:0]    q_r, q_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;

  logic [9:0] trial;
  logic [9:0] diff;
  logic       ge;
  logic       ge0;

  always_comb begin
    trial    = {rem_r, 1'b0};
    diff     = trial - {1'b0, dsr_r};
    ge       = trial >= {1'b0, dsr_r};
    ge0      = {1'b0, dividend} >= divisor;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      dsr_nxt  = divisor;
      rem_nxt  = ge0 ? ({1'b0, dividend} - divisor) : {1'b0, dividend};
      q_nxt    = {{(QW-1){1'b0}}, ge0};
      cnt_nxt  = CNT_W'(NDVI_FRAC_BITS);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[8:0] : trial[8:0];
      q_nxt   = {q_r[QW-2:0], ge};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
    q_r   <= q_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign status.busy = busy_r;
  assign status.done = done_r;
  assign quotient    = q_r;

endmodule

`default_nettype wire

// ===== src/ndvi_point_classifier.sv =====
// NDVI point classifier top level: input capture, sequencer, classification,
// running NDVI statistics and output register. Depends on npc_pkg,
// npc_divider and ndvi_point_classifier_macros.svh.
//
//   channel  | handshake          | payload
//   ---------+--------------------+---------------------------------------------
//   in       | in_valid/in_stall  | ir_level, red/green/blue_in, depth_in, covered
//   out      | out_valid/out_stall| colour, depth, keep flags, ndvi, low/high
//   cfg      | cfg_we             | cfg_index, cfg_data
//
// A transaction runs in order: a load, NDVI_FRAC_BITS shift steps and a done
// strobe in npc_divider, then classification and the output load.
// The next input is taken once the result moves to the output register.
// A stalled output holds the result; the sequencer then waits in its last state.
// Reset initialises control, statistics and config; no clearing pass.
`default_nettype none

module ndvi_point_classifier (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_ir_level,
  input  wire logic [7:0]  in_red_in,
  input  wire logic [7:0]  in_green_in,
  input  wire logic [7:0]  in_blue_in,
  input  wire logic [15:0] in_depth_in,
  input  wire logic        in_color_covered,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_red_out,
  output logic [7:0]       out_green_out,
  output logic [7:0]       out_blue_out,
  output logic [15:0]      out_depth_out,
  output logic             out_keep_display,
  output logic             out_keep_pipeline,
  output logic signed [15:0] out_ndvi_value,
  output logic             out_ndvi_valid,
  output logic signed [15:0] out_ndvi_low,
  output logic signed [15:0] out_ndvi_high,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  import npc_pkg::*;
  `include "ndvi_point_classifier_macros.svh"

  logic signed [15:0] thr_r;
  logic [7:0]         ir_thr_r;
  logic               ground_r, plant_r, tint_low_r, tint_dark_r, show_out_r;
  logic [15:0]        min_depth_r;

  npc_state_t state_r, state_nxt;

  logic [7:0]  ir_r, red_r, green_r, blue_r;
  logic [15:0] depth_r;
  logic        covered_r, neg_r, zero_r;

  logic signed [15:0] min_r, min_nxt, max_r, max_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [7:0]         ro_r, go_r, bo_r;
  logic [15:0]        do_r;
  logic               kd_r, kp_r, nv_r;
  logic signed [15:0] nd_r;

  logic         in_acc;
  logic         load_out;
  logic [7:0]   diff_mag;
  logic [8:0]   sum;
  div_status_t  div_st;
  logic [QW-1:0] quot;

  logic signed [16:0] q_ext, q_sgn;
  logic signed [15:0] ndvi;
  logic               valid, above, below, dark, deep, show, pipe;
  logic [7:0]         r_o, g_o, b_o;
  logic [15:0]        d_o;

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign diff_mag = (in_ir_level >= in_red_in) ? (in_ir_level - in_red_in)
                                               : (in_red_in - in_ir_level);
  assign sum      = {1'b0, in_ir_level} + {1'b0, in_red_in};

  npc_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_acc),
    .dividend (diff_mag),
    .divisor  (sum),
    .status   (div_st),
    .quotient (quot)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r       <= '0;
      ir_thr_r    <= '0;
      ground_r    <= 1'b0;
      plant_r     <= 1'b0;
      tint_low_r  <= 1'b0;
      tint_dark_r <= 1'b0;
      show_out_r  <= 1'b0;
      min_depth_r <= MIN_DEPTH_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_NDVI_THRESHOLD:     thr_r       <= cfg_data;
        CFG_IR_THRESHOLD:       ir_thr_r    <= cfg_data[7:0];
        CFG_GROUND_MODE:        ground_r    <= cfg_data[0];
        CFG_PLANT_MODE:         plant_r     <= cfg_data[0];
        CFG_TINT_LOW_NDVI:      tint_low_r  <= cfg_data[0];
        CFG_TINT_DARK_IR:       tint_dark_r <= cfg_data[0];
        CFG_SHOW_OUTSIDE_COLOR: show_out_r  <= cfg_data[0];
        CFG_MIN_DEPTH_MM:       min_depth_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      ir_r      <= in_ir_level;
      red_r     <= in_red_in;
      green_r   <= in_green_in;
      blue_r    <= in_blue_in;
      depth_r   <= in_depth_in;
      covered_r <= in_color_covered;
      neg_r     <= in_red_in > in_ir_level;
      zero_r    <= (sum == 9'd0);
    end
  end

  always_comb begin
    q_ext = 17'($unsigned(quot));
    q_sgn = neg_r ? -q_ext : q_ext;
    ndvi  = (q_sgn > NDVI_SAT_MAX) ? NDVI_SAT_MAX[15:0] : q_sgn[15:0];
    valid = covered_r && !zero_r;
    if (!valid) begin
      ndvi = '0;
    end
    above = valid && (ndvi > thr_r);
    below = valid && (ndvi < thr_r);
    dark  = ir_r < ir_thr_r;
    show  = 1'b1;
    pipe  = 1'b1;
    d_o   = depth_r;
    r_o   = red_r;
    g_o   = green_r;
    b_o   = blue_r;
    if (!covered_r) begin
      r_o  = ir_r;
      g_o  = ir_r;
      b_o  = ir_r;
      show = show_out_r;
      pipe = 1'b0;
    end else if (!(ground_r && plant_r)) begin
      if (ground_r) begin
        if (above) begin
          r_o  = '0;
          g_o  = '0;
          b_o  = '0;
          d_o  = '0;
          show = 1'b0;
        end
        if (dark) begin
          r_o = ir_r;
          g_o = '0;
          b_o = '0;
        end
      end
      if (plant_r) begin
        if (below) begin
          if (tint_low_r) begin
            r_o = ir_r;
            g_o = '0;
            b_o = '0;
          end else begin
            show = 1'b0;
          end
        end else if (dark) begin
          if (tint_dark_r) begin
            r_o = '0;
            g_o = '0;
            b_o = ir_r;
          end else begin
            show = 1'b0;
          end
        end
      end
    end
    deep    = d_o >= min_depth_r;
    min_nxt = (valid && (ndvi < min_r)) ? ndvi : min_r;
    max_nxt = (valid && (ndvi > max_r)) ? ndvi : max_r;
  end

  always_comb begin
    state_nxt     = state_r;
    load_out      = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_st.done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          load_out      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      min_r       <= NDVI_ONE;
      max_r       <= NDVI_NEG_ONE;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (load_out) begin
        min_r <= min_nxt;
        max_r <= max_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      ro_r <= r_o;
      go_r <= g_o;
      bo_r <= b_o;
      do_r <= d_o;
      kd_r <= show && deep;
      kp_r <= pipe && deep;
      nd_r <= ndvi;
      nv_r <= valid;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_red_out       = ro_r;
  assign out_green_out     = go_r;
  assign out_blue_out      = bo_r;
  assign out_depth_out     = do_r;
  assign out_keep_display  = kd_r;
  assign out_keep_pipeline = kp_r;
  assign out_ndvi_value    = nd_r;
  assign out_ndvi_valid    = nv_r;
  assign out_ndvi_low      = min_r;
  assign out_ndvi_high     = max_r;

  `NPC_ASSERT_NEXT(a_start_div, in_acc, state_r == ST_DIV && div_st.busy)
  `NPC_ASSERT_IMPL(a_done_in_div, div_st.done, state_r == ST_DIV)
  `NPC_ASSERT_NEXT(a_drop_taken, out_valid_r && !out_stall && state_r != ST_DONE,
                   !out_valid_r)
  `NPC_ASSERT_IMPL(a_ndvi_range, out_valid_r && nv_r,
                   nd_r <= NDVI_ONE && nd_r >= NDVI_NEG_ONE)

endmodule

`default_nettype wire
